FILE: design/qlod_pkg.sv
// Shared types and constants for the quadtree patch selector.
`timescale 1ns / 1ps
`default_nettype none
package qlod_pkg;

  localparam int MAX_DEPTH_DEF   = 3;
  localparam int QUEUE_SLOTS_DEF = 128;
  localparam logic [15:0] RATIO_RESET = 16'd128;

  // Configuration register indexes
  localparam logic CFG_HEIGHT_OFFSET = 1'b0;
  localparam logic CFG_LOD_RATIO     = 1'b1;

  typedef struct packed {
    logic signed [31:0] tile_center_x;
    logic signed [31:0] tile_center_y;
    logic [30:0]        tile_size_x;
    logic [30:0]        tile_size_y;
    logic [16:0]        tex_origin_x;
    logic [16:0]        tex_origin_y;
    logic [16:0]        tex_stride_x;
    logic [16:0]        tex_stride_y;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
  } tile_t;

  typedef struct packed {
    logic signed [31:0] leaf_center_x;
    logic signed [31:0] leaf_center_y;
    logic [30:0]        leaf_size_x;
    logic [30:0]        leaf_size_y;
    logic [16:0]        leaf_tex_x;
    logic [16:0]        leaf_tex_y;
    logic [16:0]        leaf_step_x;
    logic [16:0]        leaf_step_y;
    logic [1:0]         leaf_level;
    logic               last_leaf;
  } leaf_t;

  // Request from the sequencer to the distance test unit
  typedef struct packed {
    logic        start;
    logic [32:0] dist_x;
    logic [32:0] dist_h;
    logic [32:0] dist_z;
    logic [15:0] ratio;
    logic [31:0] edge_sum;
  } test_req_t;

  typedef struct packed {
    logic done;
    logic split;
  } test_rsp_t;

endpackage
`default_nettype wire

FILE: design/qlod_if.sv
// Valid/ready channel interfaces for tile requests and leaf results.
`timescale 1ns / 1ps
`default_nettype none
interface qlod_tile_if;
  import qlod_pkg::*;
  logic  valid;
  logic  ready;
  tile_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qlod_leaf_if;
  import qlod_pkg::*;
  logic  valid;
  logic  ready;
  leaf_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/qlod_dist_test.sv
// Shared multiplier unit: evaluates 4*(dx^2+dh^2+dz^2) < (ratio*edge_sum)^2.
`timescale 1ns / 1ps
`default_nettype none
module qlod_dist_test (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qlod_pkg::test_req_t req,
  output qlod_pkg::test_rsp_t      rsp
);
  import qlod_pkg::*;

  logic [3:0]  cnt;
  logic        busy;
  logic [65:0] prod;
  logic [2:0]  tag;
  logic        tag_valid;
  logic [47:0] m;
  logic [67:0] lhs;
  logic [95:0] rhs;
  logic [32:0] op_a;
  logic [32:0] op_b;
  logic [23:0] m_lo;
  logic [23:0] m_hi;

  assign m_lo = m[23:0];
  assign m_hi = m[47:24];

  // Operand select for the one multiplier
  always_comb begin
    case (cnt[2:0])
      3'd0: begin op_a = {17'd0, req.ratio}; op_b = {1'b0, req.edge_sum}; end
      3'd1: begin op_a = req.dist_x; op_b = req.dist_x; end
      3'd2: begin op_a = req.dist_h; op_b = req.dist_h; end
      3'd3: begin op_a = req.dist_z; op_b = req.dist_z; end
      3'd4: begin op_a = {9'd0, m_lo}; op_b = {9'd0, m_lo}; end
      3'd5: begin op_a = {9'd0, m_lo}; op_b = {9'd0, m_hi}; end
      3'd6: begin op_a = {9'd0, m_hi}; op_b = {9'd0, m_hi}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      tag_valid <= 1'b0;
      rsp.split <= 1'b0;
      rsp.done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= '0;
      tag_valid <= 1'b0;
      lhs <= '0;
      rhs <= '0;
      rsp.done <= 1'b0;
    end else if (busy) begin
      prod <= op_a * op_b;
      tag <= cnt[2:0];
      tag_valid <= (cnt <= 4'd6);
      cnt <= cnt + 4'd1;
      if (tag_valid) begin
        case (tag)
          3'd0: m <= prod[47:0];
          3'd1, 3'd2, 3'd3: lhs <= lhs + {2'b0, prod};
          3'd4: rhs <= rhs + {30'd0, prod};
          3'd5: rhs <= rhs + ({30'd0, prod} << 25);
          3'd6: rhs <= rhs + ({30'd0, prod} << 48);
          default: ;
        endcase
      end
      rsp.done <= (cnt == 4'd8);
      if (cnt == 4'd8) begin
        rsp.split <= ({26'd0, lhs, 2'b00} < rhs);
        busy <= 1'b0;
      end
    end else begin
      rsp.done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/quadtree_lod_patch_select.sv
// Top level of the quadtree terrain patch selector.
`timescale 1ns / 1ps
`default_nettype none
// Takes one terrain tile plus camera per request and walks its quadtree
// breadth-first, returning one leaf patch per result in visiting order with
// last_leaf set on the final one. A patch below MAX_DEPTH splits into four
// children (order -x+y, +x+y, -x-y, +x-y) when 4*dist^2 < (lod_ratio*(sx+sy))^2.
// Pending patches live as 8-bit paths in a small FIFO memory; each is rebuilt
// from the latched root one level per cycle. A patch passes through fetch,
// load, one build step per level and a final build step, then operand setup;
// below MAX_DEPTH it then runs the distance test in the shared 33x33
// multiplier (seven products) and either queues its four children or emits
// a leaf, while at MAX_DEPTH it emits a leaf at once. A fully split tile of
// depth 3 has 85 patches, and sink stalls hold up the walk. The block
// accepts no new tile until the last leaf is handed to the output register,
// which holds one leaf while the walk continues.
module quadtree_lod_patch_select #(
  parameter int MAX_DEPTH   = qlod_pkg::MAX_DEPTH_DEF,
  parameter int QUEUE_SLOTS = qlod_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qlod_tile_if.sink        tile,
  qlod_leaf_if.source      leaf,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import qlod_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_SLOTS);
  localparam int PTR_W = $clog2(QUEUE_SLOTS + 1);

  typedef enum logic [2:0] {
    IDLE, FETCH, LOAD, BUILD, TEST, CALC, WAIT, PUSH
  } state_t;

  state_t state;
  logic   emitting;

  logic signed [31:0] height_offset;
  logic [15:0]        lod_ratio;
  tile_t              root;

  logic [7:0]       mem [QUEUE_SLOTS];
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  logic [7:0]         path;
  logic [1:0]         level;
  logic [2:0]         depth;
  logic [1:0]         child;
  logic signed [31:0] cx, cy;
  logic [30:0]        sx, sy;
  logic [16:0]        tx, ty, stx, sty;

  test_req_t req;
  test_rsp_t rsp;

  logic [1:0]  digit;
  logic [5:0]  digit_path;
  logic [1:0]  shift_lv;
  logic [30:0] sx_half, sy_half;
  logic [16:0] stx_half, sty_half;
  logic [31:0] qx, qy;
  logic        below_max;

  function automatic logic [16:0] tex_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? 17'h1FFFF : s[16:0];
  endfunction

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (33'd0 - d) : d;
  endfunction

  // Child digit for the level being built
  assign shift_lv   = level - depth[1:0];
  assign digit_path = path[5:0] >> {shift_lv, 1'b0};
  assign digit      = digit_path[1:0];
  assign sx_half    = sx >> 1;
  assign sy_half    = sy >> 1;
  assign stx_half   = stx >> 1;
  assign sty_half   = sty >> 1;
  assign qx         = {3'd0, sx[30:2]};
  assign qy         = {3'd0, sy[30:2]};
  assign below_max  = ({1'b0, level} < 3'(MAX_DEPTH));

  assign tile.ready = (state == IDLE) && !emitting;

  qlod_dist_test u_test (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height_offset <= '0;
      lod_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT_OFFSET: height_offset <= cfg_data;
        CFG_LOD_RATIO:     lod_ratio <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Path queue: one write, one registered read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[head[IDX_W-1:0]];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = tail[IDX_W-1:0];
    wr_data = {level + 2'd1, path[3:0], child};
    if (tile.valid && tile.ready) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if (state == PUSH) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    // Pulse the distance unit for one cycle out of CALC
    req.start <= !rst && (state == CALC) && !emitting;
    if (rst) begin
      state <= IDLE;
      emitting <= 1'b0;
      leaf.valid <= 1'b0;
      head <= '0;
      tail <= '0;
    end else begin
      if (emitting) begin
        // Hold the leaf until the output register is free
        if (!leaf.valid || leaf.ready) begin
          leaf.valid <= 1'b1;
          leaf.data <= '{cx, cy, sx, sy, tx, ty, stx, sty, level, head == tail};
          emitting <= 1'b0;
          state <= (head == tail) ? IDLE : FETCH;
        end
      end else begin
        if (leaf.valid && leaf.ready) begin
          leaf.valid <= 1'b0;
        end
        case (state)
          IDLE: begin
            if (tile.valid) begin
              root <= tile.data;
              head <= '0;
              tail <= PTR_W'(1);
              state <= FETCH;
            end
          end
          FETCH: state <= LOAD;
          LOAD: begin
            path <= rd_data;
            level <= rd_data[7:6];
            depth <= 3'd1;
            cx <= root.tile_center_x;
            cy <= root.tile_center_y;
            sx <= root.tile_size_x;
            sy <= root.tile_size_y;
            tx <= root.tex_origin_x;
            ty <= root.tex_origin_y;
            stx <= root.tex_stride_x;
            sty <= root.tex_stride_y;
            head <= head + PTR_W'(1);
            state <= BUILD;
          end
          BUILD: begin
            if (depth > {1'b0, level}) begin
              state <= TEST;
            end else begin
              // Advance one level toward the patch
              sx <= sx_half;
              sy <= sy_half;
              stx <= stx_half;
              sty <= sty_half;
              cx <= digit[0] ? cx + qx : cx - qx;
              cy <= digit[1] ? cy - qy : cy + qy;
              if (digit[0]) tx <= tex_add(tx, stx_half);
              if (!digit[1]) ty <= tex_add(ty, sty_half);
              depth <= depth + 3'd1;
            end
          end
          TEST: begin
            req.dist_x <= abs_diff(cx, root.camera_x);
            req.dist_h <= abs_diff(height_offset, root.camera_y);
            req.dist_z <= abs_diff(cy, root.camera_z);
            req.ratio <= lod_ratio;
            req.edge_sum <= {1'b0, sx} + {1'b0, sy};
            if (below_max) begin
              state <= CALC;
            end else begin
              emitting <= 1'b1;
            end
          end
          CALC: begin
            state <= WAIT;
          end
          WAIT: begin
            if (rsp.done) begin
              child <= 2'd0;
              if (rsp.split) begin
                state <= PUSH;
              end else begin
                emitting <= 1'b1;
              end
            end
          end
          PUSH: begin
            // Queue the four children, one a cycle
            tail <= tail + PTR_W'(1);
            child <= child + 2'd1;
            if (child == 2'd3) state <= FETCH;
          end
          default: state <= IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
